>>> hw/rtl/pira_pkg.sv
// Shared types and constants for the positional insert/remove array list.
`default_nettype none

package pira_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned PosWidth      = 4;
  localparam int unsigned KindWidth     = 3;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned CountOutWidth = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InTdataWidth  = 40;
  localparam int unsigned OutTdataWidth = 40;

  // Default list capacity.
  localparam int unsigned DefaultDepth = 16;

  // Request kinds.
  typedef enum logic [KindWidth-1:0] {
    KIND_APPEND = 3'd0,
    KIND_POP    = 3'd1,
    KIND_READ   = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4
  } kind_e;

  // Result status codes.
  typedef enum logic [StatusWidth-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  // Control group from the sequencer to the cells.
  typedef struct packed {
    cell_op_e op;
    logic     gather;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_GATHER = 2'd1,
    FSM_DONE   = 2'd2
  } fsm_e;

endpackage

`default_nettype wire

>>> hw/rtl/pira_cell.sv
// One storage cell of the list: an entry register and a gather stage.
`default_nettype none

module pira_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned INDEX = 0
) (
  input  wire                              clk_i,
  input  wire  pira_pkg::cell_ctl_t        ctl_i,
  input  wire  [IDX_W-1:0]                 pos_i,
  input  wire  [IDX_W-1:0]                 sel_i,
  input  wire  [pira_pkg::DataWidth-1:0]   value_i,
  input  wire  [pira_pkg::DataWidth-1:0]   lower_i,
  input  wire  [pira_pkg::DataWidth-1:0]   upper_i,
  input  wire  [pira_pkg::DataWidth-1:0]   gather_up_i,
  output logic [pira_pkg::DataWidth-1:0]   entry_o,
  output logic [pira_pkg::DataWidth-1:0]   gather_o
);
  import pira_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DataWidth-1:0] entry_q, entry_d;
  logic [DataWidth-1:0] gather_q, gather_d;

  // Entry update: on insert, cells above the position shift up and the cell
  // at it loads the value; on remove, cells at and above take their upper neighbor.
  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = lower_i;
        end else if (MyIdx == pos_i) begin
          entry_d = value_i;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = upper_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Gather chain: the selected cell loads its entry, every other cell takes
  // the value from above, so the entry walks down toward cell zero.
  always_comb begin
    if (ctl_i.gather && (MyIdx == sel_i)) begin
      gather_d = entry_q;
    end else begin
      gather_d = gather_up_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q  <= entry_d;
    gather_q <= gather_d;
  end

  assign entry_o  = entry_q;
  assign gather_o = gather_q;

endmodule

`default_nettype wire

>>> hw/rtl/pira_ctrl.sv
// Request sequencer: decode, range checks, fill count and result register.
`default_nettype none

module pira_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Request side.
  input  wire                                  req_valid_i,
  output logic                                 req_ready_o,
  input  wire  [pira_pkg::KindWidth-1:0]       kind_i,
  input  wire  [pira_pkg::DataWidth-1:0]       value_i,
  input  wire  [pira_pkg::PosWidth-1:0]        pos_i,
  // Cell chain control.
  output pira_pkg::cell_ctl_t                  ctl_o,
  output logic [IDX_W-1:0]                     pos_o,
  output logic [IDX_W-1:0]                     sel_o,
  input  wire  [pira_pkg::DataWidth-1:0]       gather0_i,
  // Result side.
  output logic                                 res_valid_o,
  input  wire                                  res_ready_i,
  output logic [pira_pkg::DataWidth-1:0]       res_value_o,
  output pira_pkg::status_e                    res_status_o,
  output logic [pira_pkg::CountOutWidth-1:0]   res_count_o
);
  import pira_pkg::*;

  localparam int unsigned CmpW = CNT_W + PosWidth;

  fsm_e                 state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [IDX_W-1:0]     gcnt_q, gcnt_d;
  logic [DataWidth-1:0] rval_q, rval_d;
  status_e              rstat_q, rstat_d;

  logic                     out_valid_q, out_valid_d;
  logic [DataWidth-1:0]     out_value_q;
  status_e                  out_status_q;
  logic [CountOutWidth-1:0] out_count_q;
  logic                     out_load;

  logic [CmpW-1:0]                  pos_ext, cnt_ext;
  logic                             pos_lt, pos_le, is_full, is_empty;
  logic [CNT_W-1:0]                 count_inc, count_dec;
  logic [IDX_W-1:0]                 tail_idx, app_idx, pos_idx;
  logic [CNT_W+CountOutWidth-1:0]   count_wide;

  // Range and fill checks on the current count.
  assign pos_ext   = CmpW'(pos_i);
  assign cnt_ext   = CmpW'(count_q);
  assign pos_lt    = pos_ext < cnt_ext;
  assign pos_le    = pos_ext <= cnt_ext;
  assign is_full   = count_q == CNT_W'(DEPTH);
  assign is_empty  = count_q == '0;
  assign count_inc = count_q + CNT_W'(1);
  assign count_dec = count_q - CNT_W'(1);
  assign tail_idx  = IDX_W'(count_dec);
  assign app_idx   = IDX_W'(count_q);
  assign pos_idx   = IDX_W'(pos_i);
  assign count_wide = (CNT_W+CountOutWidth)'(count_q);

  assign req_ready_o = state_q == FSM_IDLE;

  // Next state, cell commands and result capture.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    gcnt_d     = gcnt_q;
    rval_d     = rval_q;
    rstat_d    = rstat_q;
    ctl_o.op   = OP_HOLD;
    ctl_o.gather = 1'b0;
    pos_o      = '0;
    sel_o      = '0;
    out_load   = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) begin
          state_d = FSM_DONE;
          rval_d  = '0;
          rstat_d = STAT_OK;
          unique case (kind_e'(kind_i))
            KIND_APPEND: begin
              if (is_full) begin
                rstat_d = STAT_FULL;
              end else begin
                ctl_o.op = OP_INSERT;
                pos_o    = app_idx;
                count_d  = count_inc;
              end
            end
            KIND_POP: begin
              if (is_empty) begin
                rstat_d = STAT_EMPTY;
              end else begin
                count_d      = count_dec;
                ctl_o.gather = 1'b1;
                sel_o        = tail_idx;
                gcnt_d       = tail_idx;
                state_d      = FSM_GATHER;
              end
            end
            KIND_READ: begin
              if (!pos_lt) begin
                rstat_d = STAT_BADPOS;
              end else begin
                ctl_o.gather = 1'b1;
                sel_o        = pos_idx;
                gcnt_d       = pos_idx;
                state_d      = FSM_GATHER;
              end
            end
            KIND_INSERT: begin
              if (!pos_le) begin
                rstat_d = STAT_BADPOS;
              end else if (is_full) begin
                rstat_d = STAT_FULL;
              end else begin
                ctl_o.op = OP_INSERT;
                pos_o    = pos_idx;
                count_d  = count_inc;
              end
            end
            KIND_REMOVE: begin
              if (!pos_lt) begin
                rstat_d = STAT_BADPOS;
              end else begin
                ctl_o.op = OP_REMOVE;
                pos_o    = pos_idx;
                count_d  = count_dec;
              end
            end
            default: rstat_d = STAT_BADPOS;
          endcase
        end
      end
      FSM_GATHER: begin
        // The selected entry reaches cell zero when the counter runs out.
        if (gcnt_q == '0) begin
          rval_d  = gather0_i;
          state_d = FSM_DONE;
        end else begin
          gcnt_d = gcnt_q - IDX_W'(1);
        end
      end
      FSM_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    gcnt_q  <= gcnt_d;
    rval_q  <= rval_d;
    rstat_q <= rstat_d;
    if (out_load) begin
      out_value_q  <= rval_q;
      out_status_q <= rstat_q;
      out_count_q  <= count_wide[CountOutWidth-1:0];
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_value_o  = out_value_q;
  assign res_status_o = out_status_q;
  assign res_count_o  = out_count_q;

endmodule

`default_nettype wire

>>> hw/rtl/positional_insert_remove_array_core.sv
// Top level of the positional insert/remove array list.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a chain of
// cells, one entry per cell. Each request appends, pops, reads, inserts or
// removes, and gets exactly one result with the read value, a status and
// the new count; a refused request changes nothing. Inserts and removes
// shift all affected cells at once, at the edge that accepts the request.
// Append, insert, remove and every refused request go from the idle state
// to the done state and back to idle once the output register is free. A
// read or a pop passes through the gather state first, since the selected
// entry travels down the gather chain one cell per cycle until it reaches
// cell zero. The block works on one request at a time; a finished result
// waits in the output register while the next request is taken. Entries
// are not cleared at reset; only the count, state and valid flag are.
module positional_insert_remove_array_core #(
  parameter int unsigned DEPTH = pira_pkg::DefaultDepth
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Request stream.
  input  wire                                   s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata: value [31:0], position [35:32], zero padding [39:36].
  input  wire  [pira_pkg::InTdataWidth-1:0]     s_axis_tdata_i,
  // tuser: kind [2:0].
  input  wire  [pira_pkg::KindWidth-1:0]        s_axis_tuser_i,
  // Result stream.
  output logic                                  m_axis_tvalid_o,
  input  wire                                   m_axis_tready_i,
  // tdata: read_value [31:0], count [36:32], zero padding [39:37].
  output logic [pira_pkg::OutTdataWidth-1:0]    m_axis_tdata_o,
  // tuser: status [1:0].
  output logic [pira_pkg::StatusWidth-1:0]      m_axis_tuser_o
);
  import pira_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned PadW = OutTdataWidth - DataWidth - CountOutWidth;

  cell_ctl_t                ctl;
  logic [IdxW-1:0]          cell_pos;
  logic [IdxW-1:0]          cell_sel;
  logic [DataWidth-1:0]     req_value;
  logic [PosWidth-1:0]      req_pos;
  logic [DataWidth-1:0]     entry_w  [DEPTH];
  logic [DataWidth-1:0]     gather_w [DEPTH];
  logic [DataWidth-1:0]     res_value;
  status_e                  res_status;
  logic [CountOutWidth-1:0] res_count;

  // Unpack the request fields.
  assign req_value = s_axis_tdata_i[DataWidth-1:0];
  assign req_pos   = s_axis_tdata_i[DataWidth+PosWidth-1:DataWidth];

  // Sequencer.
  pira_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW),
    .CNT_W (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_o  (s_axis_tready_o),
    .kind_i       (s_axis_tuser_i),
    .value_i      (req_value),
    .pos_i        (req_pos),
    .ctl_o        (ctl),
    .pos_o        (cell_pos),
    .sel_o        (cell_sel),
    .gather0_i    (gather_w[0]),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .res_count_o  (res_count)
  );

  // Chain of cells; each sees its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataWidth-1:0] lower_w;
    logic [DataWidth-1:0] upper_w;
    logic [DataWidth-1:0] gup_w;

    if (i == 0) begin : g_bottom
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper_w = '0;
      assign gup_w   = '0;
    end else begin : g_upper
      assign upper_w = entry_w[i+1];
      assign gup_w   = gather_w[i+1];
    end

    pira_cell #(
      .IDX_W (IdxW),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .pos_i       (cell_pos),
      .sel_i       (cell_sel),
      .value_i     (req_value),
      .lower_i     (lower_w),
      .upper_i     (upper_w),
      .gather_up_i (gup_w),
      .entry_o     (entry_w[i]),
      .gather_o    (gather_w[i])
    );
  end

  // Pack the result.
  assign m_axis_tdata_o = {{PadW{1'b0}}, res_count, res_value};
  assign m_axis_tuser_o = res_status;

`ifndef ASSERT_OFF
  // Only one request is in flight: an accepted request blocks the next cycle.
  a_one_in_flight: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o
  ) else $error("request accepted while another is in flight");

  // Cells change their entries only at the edge that accepts a request.
  a_shift_on_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ctl.op != OP_HOLD) |-> (s_axis_tvalid_i && s_axis_tready_o)
  ) else $error("cell shift without an accepted request");

  // A gather never coincides with a shift of the entries.
  a_gather_no_shift: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctl.gather |-> (ctl.op == OP_HOLD)
  ) else $error("gather issued together with a shift");

  // A refused request always returns a zero value.
  a_error_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != STAT_OK)) |->
      (m_axis_tdata_o[DataWidth-1:0] == '0)
  ) else $error("nonzero value on a refused request");
`endif

endmodule

`default_nettype wire

>>> test/positional_insert_remove_array_core_tb.sv
// Self-checking testbench for the positional insert/remove array list core.

module positional_insert_remove_array_core_tb;
  import pira_pkg::*;

  localparam int unsigned ListDepth = DefaultDepth;
  localparam int unsigned RandomRequests = 1800;
  // Requests left in the queue when both sides stop idling.
  localparam int unsigned QuietTail = 150;
  // Kinds outside the defined set, which the block must refuse.
  localparam logic [KindWidth-1:0] KindUnknownFirst = 3'd5;
  localparam logic [KindWidth-1:0] KindUnknownLast  = 3'd7;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 40;

  // One request as it travels on the input stream.
  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [DataWidth-1:0] value;
    logic [PosWidth-1:0]  position;
  } list_request_t;

  // One result as the list should answer it.
  typedef struct packed {
    logic [DataWidth-1:0]     read_value;
    status_e                  status;
    logic [CountOutWidth-1:0] count;
  } list_result_t;

  // Traffic shapes of the random part.
  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_CHURN
  } traffic_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InTdataWidth-1:0]  s_axis_tdata = '0;
  logic [KindWidth-1:0]     s_axis_tuser = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutTdataWidth-1:0] m_axis_tdata;
  logic [StatusWidth-1:0]   m_axis_tuser;

  list_request_t pending_requests[$];
  list_result_t  awaited_results[$];

  // Shadow copy of the list contents and fill level.
  logic [DataWidth-1:0] shadow_entries[ListDepth];
  int unsigned          shadow_length = 0;

  // Fill level as seen while the stimulus is built.
  int unsigned planned_length = 0;

  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  int unsigned fault_count = 0;

  positional_insert_remove_array_core #(
    .DEPTH(ListDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one accepted request to the shadow list and queue its answer.
  function automatic void predict_request(logic [KindWidth-1:0] kind,
                                          logic [DataWidth-1:0] value,
                                          logic [PosWidth-1:0] position);
    list_result_t answer;
    int unsigned  idx;
    answer.read_value = '0;
    answer.status = STAT_OK;
    case (kind)
      KIND_APPEND: begin
        if (shadow_length >= ListDepth) begin
          answer.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_length] = value;
          shadow_length++;
        end
      end
      KIND_POP: begin
        if (shadow_length == 0) begin
          answer.status = STAT_EMPTY;
        end else begin
          shadow_length--;
          answer.read_value = shadow_entries[shadow_length];
        end
      end
      KIND_READ: begin
        if (position >= shadow_length) begin
          answer.status = STAT_BADPOS;
        end else begin
          answer.read_value = shadow_entries[position];
        end
      end
      KIND_INSERT: begin
        // The position check comes before the full check.
        if (position > shadow_length) begin
          answer.status = STAT_BADPOS;
        end else if (shadow_length >= ListDepth) begin
          answer.status = STAT_FULL;
        end else begin
          for (idx = shadow_length; idx > position; idx--) begin
            shadow_entries[idx] = shadow_entries[idx - 1];
          end
          shadow_entries[position] = value;
          shadow_length++;
        end
      end
      KIND_REMOVE: begin
        if (position >= shadow_length) begin
          answer.status = STAT_BADPOS;
        end else begin
          for (idx = position; idx + 1 < shadow_length; idx++) begin
            shadow_entries[idx] = shadow_entries[idx + 1];
          end
          shadow_length--;
        end
      end
      default: begin
        answer.status = STAT_BADPOS;
      end
    endcase
    answer.count = shadow_length[CountOutWidth-1:0];
    awaited_results.push_back(answer);
  endfunction

  // Queue a request and follow the fill level it leads to.
  function automatic void queue_request(logic [KindWidth-1:0] kind,
                                        logic [DataWidth-1:0] value,
                                        logic [PosWidth-1:0] position);
    list_request_t req;
    req.kind = kind;
    req.value = value;
    req.position = position;
    pending_requests.push_back(req);
    case (kind)
      KIND_APPEND: if (planned_length < ListDepth) planned_length++;
      KIND_POP:    if (planned_length > 0) planned_length--;
      KIND_INSERT: begin
        if (position <= planned_length && planned_length < ListDepth) planned_length++;
      end
      KIND_REMOVE: if (position < planned_length) planned_length--;
      default: ;
    endcase
  endfunction

  // Choose a kind, weighted by the current traffic shape.
  function automatic logic [KindWidth-1:0] pick_kind(traffic_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      return KindWidth'($urandom_range(KindUnknownFirst, KindUnknownLast));
    end
    case (mode)
      MODE_FILL: begin
        if (roll < 40) return KIND_APPEND;
        if (roll < 75) return KIND_INSERT;
        if (roll < 87) return KIND_READ;
        if (roll < 94) return KIND_POP;
        return KIND_REMOVE;
      end
      MODE_DRAIN: begin
        if (roll < 37) return KIND_POP;
        if (roll < 72) return KIND_REMOVE;
        if (roll < 86) return KIND_READ;
        if (roll < 93) return KIND_APPEND;
        return KIND_INSERT;
      end
      default: begin
        if (roll < 22) return KIND_APPEND;
        if (roll < 42) return KIND_POP;
        if (roll < 62) return KIND_READ;
        if (roll < 82) return KIND_INSERT;
        return KIND_REMOVE;
      end
    endcase
  endfunction

  // Mostly a position inside the list, sometimes any position at all.
  function automatic logic [PosWidth-1:0] pick_position(logic [KindWidth-1:0] kind);
    int limit;
    limit = (kind == KIND_INSERT) ? int'(planned_length) : int'(planned_length) - 1;
    if (limit > 15) limit = 15;
    if (limit < 0 || $urandom_range(0, 99) < 15) begin
      return PosWidth'($urandom_range(0, 15));
    end
    return PosWidth'($urandom_range(0, limit));
  endfunction

  function automatic logic [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Request driver: presents queued requests with random idle bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tuser, s_axis_tdata[DataWidth-1:0],
                        s_axis_tdata[DataWidth+PosWidth-1:DataWidth]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() > QuietTail &&
                     (pending_requests.size() / 120) % 4 != 0 &&
                     $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          list_request_t req;
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(InTdataWidth-DataWidth-PosWidth){1'b0}}, req.position, req.value};
          s_axis_tuser <= req.kind;
        end
      end
    end
  end

  // Result monitor: checks each accepted result and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display("Unexpected result: value %h status %0d count %0d",
                     m_axis_tdata[DataWidth-1:0], m_axis_tuser,
                     m_axis_tdata[DataWidth+CountOutWidth-1:DataWidth]);
          end
        end else begin
          list_result_t want;
          want = awaited_results.pop_front();
          if (m_axis_tdata[DataWidth-1:0] !== want.read_value ||
              m_axis_tuser !== want.status ||
              m_axis_tdata[DataWidth+CountOutWidth-1:DataWidth] !== want.count) begin
            fault_count++;
            if (fault_count <= ReportLimit) begin
              $display("Mismatch: expected value %h status %0d count %0d, got %h %0d %0d",
                       want.read_value, want.status, want.count,
                       m_axis_tdata[DataWidth-1:0], m_axis_tuser,
                       m_axis_tdata[DataWidth+CountOutWidth-1:DataWidth]);
            end
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else if (pending_requests.size() > QuietTail &&
                   (pending_requests.size() / 100) % 4 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        take_gap = $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    traffic_mode_e      mode;
    logic [KindWidth-1:0] kind;
    int unsigned        n;

    // Refusals on an empty list.
    queue_request(KIND_POP, 32'h1234_5678, 4'd0);
    queue_request(KIND_READ, 32'h0, 4'd0);
    queue_request(KIND_REMOVE, 32'h0, 4'd0);
    queue_request(KIND_INSERT, 32'hDEAD_BEEF, 4'd1);
    for (kind = KindUnknownFirst; kind != KindUnknownFirst - 1; kind++) begin
      queue_request(kind, 32'hFFFF_FFFF, 4'd15);
      if (kind == KindUnknownLast) break;
    end
    // Insert into an empty list, appends, insert at the end and in the middle.
    queue_request(KIND_INSERT, 32'h8000_0000, 4'd0);
    queue_request(KIND_APPEND, 32'h7FFF_FFFF, 4'd0);
    queue_request(KIND_APPEND, 32'h0000_0000, 4'd15);
    queue_request(KIND_INSERT, 32'hFFFF_FFFF, 4'd3);
    queue_request(KIND_INSERT, 32'h5A5A_A5A5, 4'd1);
    // Reads at both ends, one just past the end and one far past it.
    queue_request(KIND_READ, 32'h0, 4'd0);
    queue_request(KIND_READ, 32'h0, 4'd4);
    queue_request(KIND_READ, 32'h0, 4'd5);
    queue_request(KIND_READ, 32'h0, 4'd15);
    // Removes in the middle and at the end, a pop, then two refused positions.
    queue_request(KIND_REMOVE, 32'h0, 4'd2);
    queue_request(KIND_REMOVE, 32'h0, 4'd3);
    queue_request(KIND_POP, 32'h0, 4'd0);
    queue_request(KIND_INSERT, 32'h0, 4'd15);
    queue_request(KIND_REMOVE, 32'h0, 4'd15);

    // Random traffic in stretches that fill, drain or churn the list.
    mode = MODE_FILL;
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0) begin
        mode = traffic_mode_e'($urandom_range(0, 2));
      end
      kind = pick_kind(mode);
      queue_request(kind, pick_value(), pick_position(kind));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(8 * 600000);
    $display("FAIL");
    $finish;
  end

endmodule
